FILE: rtl/core/kwbl_pkg.sv
// Shared types and constants of the KW1281 block link engine.
`timescale 1ns / 1ps

package kwbl_pkg;

   // Input event codes carried in the func field.
   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_LINE     = 2'd1;
   localparam logic [1:0] FUNC_HOST     = 2'd2;
   localparam logic [1:0] FUNC_RX_START = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_ATTEMPTS     = 2'd0;
   localparam logic [1:0] CSR_BYTE_GAP_MS      = 2'd1;
   localparam logic [1:0] CSR_BYTE_TIMEOUT_MS  = 2'd2;
   localparam logic [1:0] CSR_BLOCK_TIMEOUT_MS = 2'd3;

   // Configuration reset values.
   localparam logic [3:0]  MAX_ATTEMPTS_RST     = 4'd1;
   localparam logic [7:0]  BYTE_GAP_MS_RST      = 8'd2;
   localparam logic [7:0]  BYTE_TIMEOUT_MS_RST  = 8'd40;
   localparam logic [15:0] BLOCK_TIMEOUT_MS_RST = 16'd500;

   // Completion status codes.
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_ECHO_BAD    = 4'd1;
   localparam logic [3:0] ST_BAD_INVERSE = 4'd2;
   localparam logic [3:0] ST_NO_INVERSE  = 4'd3;
   localparam logic [3:0] ST_NO_START    = 4'd4;
   localparam logic [3:0] ST_BYTE_TMO    = 4'd5;
   localparam logic [3:0] ST_ACK_ECHO    = 4'd6;
   localparam logic [3:0] ST_NO_END      = 4'd7;
   localparam logic [3:0] ST_BAD_END     = 4'd8;

   // Input item of one transfer.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_payload_type;

   // Result item of one transfer.
   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       host_valid;
      logic [7:0] host_byte;
      logic [7:0] byte_position;
      logic       need_byte;
      logic       done_res;
      logic [3:0] status;
   } rsp_payload_type;

   // Current configuration seen by the engine.
   typedef struct packed {
      logic [3:0]  max_attempts;
      logic [7:0]  byte_gap_ms;
      logic [7:0]  byte_timeout_ms;
      logic [15:0] block_timeout_ms;
   } cfg_type;

endpackage

FILE: rtl/core/kwbl_csr.sv
// Configuration registers of the KW1281 block link engine.
`timescale 1ns / 1ps

module kwbl_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [1:0]           wr_index,
   input  logic [15:0]          wr_data,
   output kwbl_pkg::cfg_type    cfg
);

   kwbl_pkg::cfg_type cfg_ff;
   kwbl_pkg::cfg_type cfg_in;

   // Decode the register index and replace the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            kwbl_pkg::CSR_MAX_ATTEMPTS:     cfg_in.max_attempts     = wr_data[3:0];
            kwbl_pkg::CSR_BYTE_GAP_MS:      cfg_in.byte_gap_ms      = wr_data[7:0];
            kwbl_pkg::CSR_BYTE_TIMEOUT_MS:  cfg_in.byte_timeout_ms  = wr_data[7:0];
            kwbl_pkg::CSR_BLOCK_TIMEOUT_MS: cfg_in.block_timeout_ms = wr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   // Register file with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts     <= kwbl_pkg::MAX_ATTEMPTS_RST;
         cfg_ff.byte_gap_ms      <= kwbl_pkg::BYTE_GAP_MS_RST;
         cfg_ff.byte_timeout_ms  <= kwbl_pkg::BYTE_TIMEOUT_MS_RST;
         cfg_ff.block_timeout_ms <= kwbl_pkg::BLOCK_TIMEOUT_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/kwbl_engine.sv
// Link state machine: holds the block state and works out one event per step.
`timescale 1ns / 1ps

module kwbl_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  kwbl_pkg::req_payload_type item,
   input  kwbl_pkg::cfg_type         cfg,
   output kwbl_pkg::rsp_payload_type result
);

   // Phase codes.
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_S_ECHO  = 4'd1;
   localparam logic [3:0] PH_S_REPLY = 4'd2;
   localparam logic [3:0] PH_S_GAP   = 4'd3;
   localparam logic [3:0] PH_S_NEED  = 4'd4;
   localparam logic [3:0] PH_E_ECHO  = 4'd5;
   localparam logic [3:0] PH_R_START = 4'd6;
   localparam logic [3:0] PH_R_GAP   = 4'd7;
   localparam logic [3:0] PH_R_ECHO  = 4'd8;
   localparam logic [3:0] PH_R_WAIT  = 4'd9;
   localparam logic [3:0] PH_R_END   = 4'd10;

   localparam logic [7:0] BLOCK_END     = 8'h03;
   localparam logic [7:0] MIN_BLOCK_LEN = 8'd3;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  cur_ff, cur_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  bdone_ff, bdone_in;
   logic [3:0]  att_ff, att_in;
   logic [15:0] tmr_ff, tmr_in;

   logic [15:0] tmr_dec;
   logic        tick_exp;
   logic [7:0]  bdone_inc;
   logic [7:0]  len_rx;
   logic        is_tick;
   logic        is_line;
   logic        is_host;

   kwbl_pkg::rsp_payload_type res;

   // A block always carries at least three bytes before the end byte.
   function automatic logic [7:0] block_count(input logic [7:0] len);
      block_count = (len < MIN_BLOCK_LEN) ? MIN_BLOCK_LEN : len;
   endfunction

   // Shared helpers of the step logic.
   assign tmr_dec   = (tmr_ff != 16'd0) ? tmr_ff - 16'd1 : 16'd0;
   assign tick_exp  = (tmr_dec == 16'd0);
   assign bdone_inc = bdone_ff + 8'd1;
   assign len_rx    = (bdone_ff == 8'd0) ? cur_ff : len_ff;
   assign is_tick   = (item.func == kwbl_pkg::FUNC_TICK);
   assign is_line   = (item.func == kwbl_pkg::FUNC_LINE);
   assign is_host   = (item.func == kwbl_pkg::FUNC_HOST);

   // Next state and result for the event at hand.
   always_comb begin
      phase_in = phase_ff;
      cur_in   = cur_ff;
      len_in   = len_ff;
      bdone_in = bdone_ff;
      att_in   = att_ff;
      tmr_in   = tmr_ff;
      res      = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (is_host) begin
               len_in   = item.data_byte;
               cur_in   = item.data_byte;
               bdone_in = 8'd0;
               if (cfg.max_attempts == 4'd0) begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = kwbl_pkg::ST_NO_INVERSE;
               end else begin
                  att_in      = cfg.max_attempts - 4'd1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = item.data_byte;
                  phase_in    = PH_S_ECHO;
               end
            end else if (item.func == kwbl_pkg::FUNC_RX_START) begin
               len_in   = 8'd0;
               bdone_in = 8'd0;
               tmr_in   = cfg.block_timeout_ms;
               phase_in = PH_R_START;
            end
         end
         PH_S_ECHO: begin
            if (is_line) begin
               res.byte_position = bdone_ff;
               if (item.data_byte == cur_ff) begin
                  tmr_in   = {8'd0, cfg.byte_timeout_ms};
                  phase_in = PH_S_REPLY;
               end else begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = kwbl_pkg::ST_ECHO_BAD;
               end
            end
         end
         PH_S_REPLY: begin
            if (is_line) begin
               res.byte_position = bdone_ff;
               if (item.data_byte == ~cur_ff) begin
                  bdone_in = bdone_inc;
                  if (cfg.byte_gap_ms != 8'd0) begin
                     tmr_in   = {8'd0, cfg.byte_gap_ms};
                     phase_in = PH_S_GAP;
                  end else if (bdone_inc >= block_count(len_ff)) begin
                     res.tx_valid = 1'b1;
                     res.tx_byte  = BLOCK_END;
                     phase_in     = PH_E_ECHO;
                  end else begin
                     phase_in = PH_S_NEED;
                  end
               end else begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = kwbl_pkg::ST_BAD_INVERSE;
               end
            end else if (is_tick) begin
               tmr_in = tmr_dec;
               if (tick_exp) begin
                  res.byte_position = bdone_ff;
                  if (att_ff != 4'd0) begin
                     att_in       = att_ff - 4'd1;
                     res.tx_valid = 1'b1;
                     res.tx_byte  = cur_ff;
                     phase_in     = PH_S_ECHO;
                  end else begin
                     phase_in     = PH_IDLE;
                     res.done_res = 1'b1;
                     res.status   = kwbl_pkg::ST_NO_INVERSE;
                  end
               end
            end
         end
         PH_S_GAP: begin
            if (is_tick) begin
               tmr_in = tmr_dec;
               if (tick_exp) begin
                  res.byte_position = bdone_ff;
                  if (bdone_ff >= block_count(len_ff)) begin
                     res.tx_valid = 1'b1;
                     res.tx_byte  = BLOCK_END;
                     phase_in     = PH_E_ECHO;
                  end else begin
                     phase_in = PH_S_NEED;
                  end
               end
            end
         end
         PH_S_NEED: begin
            if (is_host) begin
               cur_in            = item.data_byte;
               res.byte_position = bdone_ff;
               if (cfg.max_attempts == 4'd0) begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = kwbl_pkg::ST_NO_INVERSE;
               end else begin
                  att_in       = cfg.max_attempts - 4'd1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = item.data_byte;
                  phase_in     = PH_S_ECHO;
               end
            end
         end
         PH_E_ECHO: begin
            if (is_line) begin
               res.byte_position = bdone_ff;
               phase_in          = PH_IDLE;
               res.done_res      = 1'b1;
               res.status        = (item.data_byte == BLOCK_END) ? kwbl_pkg::ST_OK
                                                                 : kwbl_pkg::ST_ECHO_BAD;
            end
         end
         PH_R_START, PH_R_WAIT: begin
            if (is_line) begin
               // Take the byte and answer it at once, or after the gap when one is set.
               cur_in            = item.data_byte;
               res.byte_position = bdone_ff;
               if (cfg.byte_gap_ms == 8'd0) begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = ~item.data_byte;
                  phase_in     = PH_R_ECHO;
               end else begin
                  tmr_in   = {8'd0, cfg.byte_gap_ms};
                  phase_in = PH_R_GAP;
               end
            end else if (is_tick) begin
               tmr_in = tmr_dec;
               if (tick_exp) begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  if (phase_ff == PH_R_START) begin
                     res.status = kwbl_pkg::ST_NO_START;
                  end else begin
                     res.byte_position = bdone_ff;
                     res.status        = kwbl_pkg::ST_BYTE_TMO;
                  end
               end
            end
         end
         PH_R_GAP: begin
            if (is_tick) begin
               tmr_in = tmr_dec;
               if (tick_exp) begin
                  res.byte_position = bdone_ff;
                  res.tx_valid      = 1'b1;
                  res.tx_byte       = ~cur_ff;
                  phase_in          = PH_R_ECHO;
               end
            end
         end
         PH_R_ECHO: begin
            if (is_line) begin
               res.byte_position = bdone_ff;
               if (item.data_byte == ~cur_ff) begin
                  len_in         = len_rx;
                  res.host_valid = 1'b1;
                  res.host_byte  = cur_ff;
                  bdone_in       = bdone_inc;
                  tmr_in         = {8'd0, cfg.byte_timeout_ms};
                  phase_in       = (bdone_inc >= block_count(len_rx)) ? PH_R_END : PH_R_WAIT;
               end else begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  res.status   = kwbl_pkg::ST_ACK_ECHO;
               end
            end
         end
         PH_R_END: begin
            if (is_line) begin
               res.byte_position = bdone_ff;
               phase_in          = PH_IDLE;
               res.done_res      = 1'b1;
               res.status        = (item.data_byte == BLOCK_END) ? kwbl_pkg::ST_OK
                                                                 : kwbl_pkg::ST_BAD_END;
            end else if (is_tick) begin
               tmr_in = tmr_dec;
               if (tick_exp) begin
                  res.byte_position = bdone_ff;
                  phase_in          = PH_IDLE;
                  res.done_res      = 1'b1;
                  res.status        = kwbl_pkg::ST_NO_END;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      res.need_byte = (phase_in == PH_S_NEED);
   end

   // Block state, advanced once per transfer through the engine.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff   <= 8'd0;
         len_ff   <= 8'd0;
         bdone_ff <= 8'd0;
         att_ff   <= 4'd0;
         tmr_ff   <= 16'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         len_ff   <= len_in;
         bdone_ff <= bdone_in;
         att_ff   <= att_in;
         tmr_ff   <= tmr_in;
      end
   end

   assign result = res;

`ifndef ASSERT_OFF
   // A finished block always leaves the engine idle.
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      step && res.done_res |=> phase_ff == PH_IDLE)
      else $error("engine not idle after block completion");

   // Status is only meaningful on a completion.
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      !res.done_res |-> res.status == kwbl_pkg::ST_OK)
      else $error("status set without completion");

   // Half duplex: a delivered byte never coincides with a line transmit.
   a_half_duplex: assert property (@(posedge clock) disable iff (reset)
      !(res.host_valid && res.tx_valid))
      else $error("host delivery and transmit in one step");

   // A send request from idle always either transmits or fails at once.
   a_idle_send: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && is_host |-> res.tx_valid || res.done_res)
      else $error("host byte taken in idle without action");
`endif

endmodule

FILE: rtl/core/kw1281_block_link_engine.sv
// Top level of the KW1281 block link engine: channel registers around the engine.
`timescale 1ns / 1ps

// The engine takes one event per transfer (1 ms tick, line byte, host byte or
// start of a receive) and returns exactly one result per event. A transfer is
// taken in every clock cycle while req_ready is high. An accepted event is held
// in the input register and its result in the result register, which sit on
// either side of the state update. A result waiting on rsp_ready holds one
// event in the input register, after which req_ready drops. Configuration
// writes are taken in every cycle and must only be issued while no block is in
// progress. There is no clearing pass after reset.
module kw1281_block_link_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kwbl_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kwbl_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_data
);

   logic                      s1_valid_ff, s1_valid_in;
   kwbl_pkg::req_payload_type s1_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   kwbl_pkg::rsp_payload_type rsp_ff;
   logic                      advance;
   kwbl_pkg::cfg_type         cfg;
   kwbl_pkg::rsp_payload_type result;

   // The held event moves into the result register when that register is free.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;

   kwbl_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   kwbl_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Channel control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   // An accepted event is held in the input register on the next cycle.
   a_take_event: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted event not held");

   // Every event that enters the engine produces a pending result.
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("engine step without result");

   // A stalled result stays valid and unchanged until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled result changed");
`endif

endmodule
